// ----- hw/rtl/hfi_pkg.sv -----
`default_nettype none
package hfi_pkg;

   // Conversion kind codes
   localparam logic KIND_SINGLE = 1'b0;
   localparam logic KIND_DOUBLE = 1'b1;

   // Field widths
   localparam int unsigned FRAC_W  = 56;
   localparam int unsigned HEXP_W  = 7;
   localparam int unsigned LZ_W    = 6;
   localparam int unsigned BEXP_W  = 12;
   localparam int unsigned MANT_W  = 52;
   localparam int unsigned NBYTES  = 7;

   // Exponent rebasing: bexp = 4*E + offset - lz
   //   single: 4*(E-64) - 1 - lz + 127
   //   double: 4*(E-64) - (lz+1) + 1023
   localparam logic signed [BEXP_W-1:0] SGL_EXP_OFFSET = -12'sd130;
   localparam logic signed [BEXP_W-1:0] DBL_EXP_OFFSET = 12'sd766;

   // Saturation thresholds (all-ones exponent code)
   localparam logic signed [BEXP_W-1:0] SGL_EXP_SAT = 12'sd255;
   localparam logic signed [BEXP_W-1:0] DBL_EXP_SAT = 12'sd2047;

   // Largest finite magnitudes
   localparam logic [30:0] SGL_MAX_MAG = 31'h7F7F_FFFF;
   localparam logic [62:0] DBL_MAX_MAG = 63'h7FEF_FFFF_FFFF_FFFF;

   // Decoded word, stage 1
   typedef struct packed {
      logic              valid;
      logic              kind;
      logic              sign;
      logic              zero;
      logic [HEXP_W-1:0] expo;
      logic [FRAC_W-1:0] frac;
   } hfi_dec_type;

   // Word with leading-zero count, stage 3
   typedef struct packed {
      logic              valid;
      logic              kind;
      logic              sign;
      logic              zero;
      logic [HEXP_W-1:0] expo;
      logic [FRAC_W-1:0] frac;
      logic [LZ_W-1:0]   lz;
   } hfi_norm_type;

   // Normalized mantissa and rebased exponent, stage 4
   typedef struct packed {
      logic                     valid;
      logic                     kind;
      logic                     sign;
      logic                     zero;
      logic signed [BEXP_W-1:0] bexp;
      logic [MANT_W-1:0]        mant;
   } hfi_scaled_type;

endpackage
`default_nettype wire

// ----- hw/rtl/hfi_if.sv -----
`default_nettype none
// Request channel: one IBM word per beat
interface hfi_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] raw_word;

   modport source (output valid, output kind, output raw_word, input ready);
   modport sink   (input valid, input kind, input raw_word, output ready);
endinterface

// Response channel: one IEEE pattern per beat
interface hfi_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] ieee_bits;

   modport source (output valid, output ieee_bits, input ready);
   modport sink   (input valid, input ieee_bits, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ibm_hex_float_to_ieee.sv -----
`default_nettype none
// IBM hexadecimal float to IEEE 754 converter.
//
// req_ch (sink): one beat carries kind and raw_word. kind selects single
//   (IBM word in raw_word[31:0], binary32 result) or double (64-bit word,
//   binary64 result). Upper bits of raw_word are ignored for single.
// rsp_ch (source): one beat per request, in order, carries ieee_bits;
//   single results sit in the low 32 bits with the upper half zero.
// Pipeline: the request beat passes through the decode, byte leading-zero
//   count, byte select, shift/rebase and pack registers to the response beat.
// Throughput: one word per cycle while the response is not held; every
//   stage is a plain register stage and the pipeline has no loops.
// Stall: when the response is held (valid and not ready) the whole
//   pipeline freezes and req_ch.ready drops in the same cycle; nothing is
//   lost or repeated. ready is high whenever the output register is empty
//   or being drained.
// Reset: synchronous, clears all stage valid bits; the block takes a beat
//   in the first cycle after reset.
// Rounding is toward zero; overflow saturates to the largest finite value,
//   underflow gives signed zero.
module ibm_hex_float_to_ieee
   import hfi_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   hfi_req_if.sink     req_ch,
   hfi_rsp_if.source   rsp_ch
);

   logic           enable;
   logic           out_valid;
   logic [63:0]    out_bits;
   hfi_dec_type    dec;
   hfi_norm_type   norm;
   hfi_scaled_type scaled;

   // Global advance: output empty or taken this cycle
   assign enable       = !out_valid || rsp_ch.ready;
   assign req_ch.ready = enable;

   hfi_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_ch.valid),
      .kind     (req_ch.kind),
      .raw_word (req_ch.raw_word),
      .dec_ff   (dec)
   );

   hfi_lzc u_lzc (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .dec     (dec),
      .norm_ff (norm)
   );

   hfi_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .norm      (norm),
      .scaled_ff (scaled)
   );

   hfi_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .scaled       (scaled),
      .out_valid_ff (out_valid),
      .out_bits_ff  (out_bits)
   );

   assign rsp_ch.valid     = out_valid;
   assign rsp_ch.ieee_bits = out_bits;

endmodule
`default_nettype wire

// ----- hw/rtl/hfi_decode.sv -----
`default_nettype none
module hfi_decode
   import hfi_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   input  wire logic          in_valid,
   input  wire logic          kind,
   input  wire logic [63:0]   raw_word,
   output hfi_dec_type        dec_ff
);

   hfi_dec_type dec_in;

   // Split the word; single fraction is left-aligned into 56 bits
   always_comb begin
      dec_in.valid = in_valid;
      dec_in.kind  = kind;
      if (kind == KIND_DOUBLE) begin
         dec_in.sign = raw_word[63];
         dec_in.expo = raw_word[62:56];
         dec_in.frac = raw_word[55:0];
      end else begin
         dec_in.sign = raw_word[31];
         dec_in.expo = raw_word[30:24];
         dec_in.frac = {raw_word[23:0], 32'd0};
      end
      // signed zero and IBM zero both reduce to the sign alone
      dec_in.zero = (dec_in.frac == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else if (enable) begin
         dec_ff <= dec_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/hfi_lzc.sv -----
`default_nettype none
module hfi_lzc
   import hfi_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   enable,
   input  wire hfi_dec_type dec,
   output hfi_norm_type norm_ff
);

   // leading zeros inside one byte (don't care when byte is zero)
   function automatic logic [2:0] byte_lz(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) n = 3'(7 - i);
      end
      return n;
   endfunction

   hfi_dec_type        dec2_ff;
   logic [2:0]         blz_ff [NBYTES];
   logic [2:0]         blz_in [NBYTES];
   logic [NBYTES-1:0]  bnz_ff;
   logic [NBYTES-1:0]  bnz_in;
   hfi_norm_type       norm_in;

   // Stage 2: per-byte zero flag and leading-zero count
   always_comb begin
      for (int k = 0; k < NBYTES; k++) begin
         bnz_in[k] = (dec.frac[8*k +: 8] != 8'd0);
         blz_in[k] = byte_lz(dec.frac[8*k +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec2_ff.valid <= 1'b0;
      end else if (enable) begin
         dec2_ff <= dec;
         bnz_ff  <= bnz_in;
         for (int k = 0; k < NBYTES; k++) begin
            blz_ff[k] <= blz_in[k];
         end
      end
   end

   // Stage 3: pick highest nonzero byte, byte 6 is the top of the fraction
   always_comb begin
      norm_in.valid = dec2_ff.valid;
      norm_in.kind  = dec2_ff.kind;
      norm_in.sign  = dec2_ff.sign;
      norm_in.zero  = dec2_ff.zero;
      norm_in.expo  = dec2_ff.expo;
      norm_in.frac  = dec2_ff.frac;
      norm_in.lz    = '0;
      for (int k = 0; k < NBYTES; k++) begin
         if (bnz_ff[k]) norm_in.lz = {3'(NBYTES - 1 - k), blz_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff.valid <= 1'b0;
      end else if (enable) begin
         norm_ff <= norm_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/hfi_shift.sv -----
`default_nettype none
module hfi_shift
   import hfi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  wire hfi_norm_type norm,
   output hfi_scaled_type scaled_ff
);

   logic [FRAC_W-1:0]        shifted;
   logic signed [BEXP_W-1:0] exp4;
   logic signed [BEXP_W-1:0] offset;
   hfi_scaled_type           scaled_in;

   // Leading one lands on bit 55; keep the 52 bits below it
   always_comb begin
      shifted = norm.frac << norm.lz;
      exp4    = $signed({3'b000, norm.expo, 2'b00});
      offset  = (norm.kind == KIND_DOUBLE) ? DBL_EXP_OFFSET : SGL_EXP_OFFSET;

      scaled_in.valid = norm.valid;
      scaled_in.kind  = norm.kind;
      scaled_in.sign  = norm.sign;
      scaled_in.zero  = norm.zero;
      scaled_in.bexp  = exp4 + offset - $signed({6'd0, norm.lz});
      scaled_in.mant  = shifted[FRAC_W-2:3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scaled_ff.valid <= 1'b0;
      end else if (enable) begin
         scaled_ff <= scaled_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/hfi_pack.sv -----
`default_nettype none
module hfi_pack
   import hfi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        enable,
   input  wire hfi_scaled_type scaled,
   output logic             out_valid_ff,
   output logic [63:0]      out_bits_ff
);

   logic [63:0] out_bits_in;

   // Saturate, flush to zero, or assemble the IEEE pattern
   always_comb begin
      if (scaled.kind == KIND_DOUBLE) begin
         if (scaled.zero || scaled.bexp <= 12'sd0) begin
            out_bits_in = {scaled.sign, 63'd0};
         end else if (scaled.bexp >= DBL_EXP_SAT) begin
            out_bits_in = {scaled.sign, DBL_MAX_MAG};
         end else begin
            out_bits_in = {scaled.sign, scaled.bexp[10:0], scaled.mant};
         end
      end else begin
         if (scaled.zero || scaled.bexp <= 12'sd0) begin
            out_bits_in = {32'd0, scaled.sign, 31'd0};
         end else if (scaled.bexp >= SGL_EXP_SAT) begin
            out_bits_in = {32'd0, scaled.sign, SGL_MAX_MAG};
         end else begin
            out_bits_in = {32'd0, scaled.sign, scaled.bexp[7:0],
                           scaled.mant[MANT_W-1 -: 23]};
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= scaled.valid;
         out_bits_ff  <= out_bits_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/hfi_checker.sv -----
`default_nettype none
module hfi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] ieee_bits
);

   // Held response beat keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ieee_bits))
      else $error("response changed while stalled");

   // Requests only back up behind a held response
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request side stalled without a held response");

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Never infinity or NaN: double exponent field and single exponent field
   a_finite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ieee_bits[62:52] != 11'h7FF &&
         (ieee_bits[63:32] != 32'd0 || ieee_bits[30:23] != 8'hFF))
      else $error("non-finite result");

endmodule

bind ibm_hex_float_to_ieee hfi_checker u_hfi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .ieee_bits (rsp_ch.ieee_bits)
);
`default_nettype wire
